// ===== hw/rtl/vfa_pkg.sv =====
// Shared types, constants and tables for the variable flip angle T1 fit block.
`default_nettype none
package vfa_pkg;

    localparam int MAX_POINTS   = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int CNT_W  = 7;
    localparam int Z_W    = 20;
    localparam int CS_W   = 34;
    localparam int OPD_W  = 64;
    localparam int PROD_W = 128;
    localparam int NUM_W  = 104;
    localparam int DEN_W  = 72;
    localparam int QUO_W  = 32;

    localparam logic [20:0] HALF_PI       = 21'd102944;
    localparam logic [20:0] PI_Q16        = 21'd205887;
    localparam logic [20:0] THREE_HALF_PI = 21'd308831;
    localparam logic [20:0] TWO_PI        = 21'd411775;
    localparam logic signed [CS_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [31:0] XY_LIMIT = 32'd2147483647;

    typedef enum logic [2:0] {
        FIT_OK       = 3'd0,
        FIT_FEW      = 3'd1,
        FIT_SINGULAR = 3'd2,
        FIT_SLOPE    = 3'd3,
        FIT_OVERFLOW = 3'd4
    } t_fit_status;

    typedef enum logic [0:0] {
        CFG_TR = 1'b0,
        CFG_B1 = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] flip_angle;
        logic [23:0] signal_value;
        logic        last_point;
    } t_in_item;

    typedef struct packed {
        logic [31:0] t1_time;
        logic [31:0] m0_value;
        t_fit_status fit_status;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [OPD_W-1:0] a;
        logic [OPD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic                  start;
        logic signed [Z_W-1:0] z;
    } t_cor_req;

    typedef struct packed {
        logic                   done;
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } t_cor_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_TH_MUL, S_TH_MOD, S_CORDIC, S_X_MUL, S_X_DIV, S_Y_DIV,
        S_XX_MUL, S_XY_MUL, S_PT_END, S_FIT_CHK, S_DEN1, S_DEN2, S_NUM1,
        S_NUM2, S_SLOPE_CHK, S_SLOPE_DIV, S_NORM, S_LOG_SQ, S_LN_HI, S_LN_LO,
        S_T1_DIV, S_M0_MUL, S_M0_DEN, S_M0_DIV, S_OUT
    } t_state;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30386;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/variable_flip_angle_t1_fit_top.sv =====
// Top level: sequencer, accumulators and fit arithmetic of the VFA T1 fit.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one measurement per
// request: flip angle, signal and a last-point flag. o_in_stall is low only
// while the sequencer is idle. Each measurement runs through the sequence
// CORDIC, two 32-step divides and four passes through the shared
// four-partial-product multiplier. On a request flagged last the fit follows,
// mostly the 32 squarings of the logarithm through the shared multiplier, plus
// three 32-step divides and a normalization of the slope, longer when the slope
// is small. Then one result request appears on the output channel
// (o_out_valid / i_out_stall / o_out_data) and the sums clear.
// The result sits in an output register; a new measurement may be accepted
// while it waits. If a fit finishes while the previous result is still
// stalled, the sequencer holds until the output register frees.
// Config writes (i_cfg_we) set TR and B1 and are expected only while idle.
// Synchronous reset clears the sums, returns TR to 1280 and B1 to 1.0.
`default_nettype none
module variable_flip_angle_t1_fit_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire vfa_pkg::t_cfg_index i_cfg_index,
    input  wire logic [15:0]         i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire vfa_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output vfa_pkg::t_out_item       o_out_data
);
    import vfa_pkg::*;

    t_state                   r_state, n_state;
    logic                     r_issued;
    logic [15:0]              r_tr;
    logic [15:0]              r_b1;
    logic [15:0]              r_flip;
    logic [23:0]              r_sig;
    logic                     r_last;
    logic [20:0]              r_theta;
    logic signed [Z_W-1:0]    r_z;
    logic                     r_fsign;
    logic signed [CS_W-1:0]   r_c;
    logic signed [CS_W-1:0]   r_s;
    logic signed [31:0]       r_x;
    logic signed [31:0]       r_y;
    logic signed [47:0]       r_sum_x;
    logic signed [47:0]       r_sum_y;
    logic [63:0]              r_sum_xx;
    logic signed [63:0]       r_sum_xy;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ov;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_den;
    logic signed [PROD_W-1:0] r_num;
    logic [31:0]              r_slope;
    logic [31:0]              r_f;
    logic [31:0]              r_frac;
    logic [4:0]               r_lz;
    logic [4:0]               r_iter;
    logic [63:0]              r_nl;
    logic [31:0]              r_t1;
    logic [31:0]              r_m0;
    t_fit_status              r_status;
    logic                     r_out_valid;
    t_out_item                r_out;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_cor_req cor_req;
    t_cor_rsp cor_rsp;

    logic                     in_acc;
    logic                     out_free;
    logic                     use_mul;
    logic                     use_div;
    logic                     use_cor;
    logic [47:0]              sx_mag;
    logic [47:0]              sy_mag;
    logic [63:0]              sxy_mag;
    logic [CS_W-1:0]          c_mag;
    logic [CS_W-1:0]          s_mag;
    logic [31:0]              x_mag;
    logic [31:0]              y_mag;
    logic [37:0]              v_log;
    logic [32:0]              one_minus;
    logic [32:0]              th_sum;
    logic signed [21:0]       th_s;
    logic [32:0]              fsq;
    logic [31:0]              q_mag;
    logic [31:0]              q_clip;
    logic                     q_over;
    logic [64:0]              xx_sum;
    logic signed [65:0]       xy_sum;
    logic signed [PROD_W-1:0] sy_shift;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign sx_mag    = r_sum_x[47] ? 48'(-r_sum_x) : 48'(r_sum_x);
    assign sy_mag    = r_sum_y[47] ? 48'(-r_sum_y) : 48'(r_sum_y);
    assign sxy_mag   = r_sum_xy[63] ? 64'(-r_sum_xy) : 64'(r_sum_xy);
    assign c_mag     = r_c[CS_W-1] ? CS_W'(-r_c) : CS_W'(r_c);
    assign s_mag     = r_s[CS_W-1] ? CS_W'(-r_s) : CS_W'(r_s);
    assign x_mag     = r_x[31] ? 32'(-r_x) : 32'(r_x);
    assign y_mag     = r_y[31] ? 32'(-r_y) : 32'(r_y);
    assign v_log     = {({1'b0, r_lz} + 6'd1), 32'd0} - {6'd0, r_frac};
    assign one_minus = 33'h1_0000_0000 - {1'b0, r_slope};
    assign th_sum    = {1'b0, mul_rsp.prod[31:0]} + 33'd2048;
    assign th_s      = $signed({1'b0, r_theta});
    assign fsq       = mul_rsp.prod[63:31];
    assign q_mag     = div_rsp.quo;
    assign q_over    = q_mag > XY_LIMIT;
    assign q_clip    = q_over ? XY_LIMIT : q_mag;
    assign xx_sum    = {1'b0, r_sum_xx} + {1'b0, mul_rsp.prod[63:0]};
    assign xy_sum    = 66'(r_sum_xy) + $signed(mul_rsp.prod[65:0]);
    assign sy_shift  = $signed({{48{r_sum_y[47]}}, r_sum_y, 32'd0});

    vfa_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));
    vfa_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));
    vfa_cordic u_cordic (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(cor_req),
                         .o_rsp(cor_rsp));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (r_cnt >= CNT_W'(MAX_POINTS)) ? S_PT_END : S_TH_MUL;
                end
            end
            S_TH_MUL:    if (mul_rsp.done) n_state = S_TH_MOD;
            S_TH_MOD:    if (r_theta < TWO_PI) n_state = S_CORDIC;
            S_CORDIC: begin
                if (cor_rsp.done) begin
                    n_state = (cor_rsp.s == '0) ? S_PT_END : S_X_MUL;
                end
            end
            S_X_MUL:     if (mul_rsp.done) n_state = S_X_DIV;
            S_X_DIV:     if (div_rsp.done) n_state = S_Y_DIV;
            S_Y_DIV:     if (div_rsp.done) n_state = S_XX_MUL;
            S_XX_MUL:    if (mul_rsp.done) n_state = S_XY_MUL;
            S_XY_MUL:    if (mul_rsp.done) n_state = S_PT_END;
            S_PT_END:    n_state = r_last ? S_FIT_CHK : S_IDLE;
            S_FIT_CHK: begin
                n_state = (r_cnt < CNT_W'(2) || r_ov) ? S_OUT : S_DEN1;
            end
            S_DEN1:      if (mul_rsp.done) n_state = S_DEN2;
            S_DEN2:      if (mul_rsp.done) n_state = S_NUM1;
            S_NUM1:      if (mul_rsp.done) n_state = S_NUM2;
            S_NUM2:      if (mul_rsp.done) n_state = S_SLOPE_CHK;
            S_SLOPE_CHK: begin
                if (r_den[PROD_W-1] || r_den == '0 || r_num[PROD_W-1] || r_num == '0
                        || r_num >= r_den) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SLOPE_DIV;
                end
            end
            S_SLOPE_DIV: begin
                if (div_rsp.done) n_state = (div_rsp.quo == '0) ? S_OUT : S_NORM;
            end
            S_NORM:      if (r_f[31]) n_state = S_LOG_SQ;
            S_LOG_SQ:    if (mul_rsp.done && r_iter == 5'd31) n_state = S_LN_HI;
            S_LN_HI:     if (mul_rsp.done) n_state = S_LN_LO;
            S_LN_LO:     if (mul_rsp.done) n_state = S_T1_DIV;
            S_T1_DIV:    if (div_rsp.done) n_state = S_M0_MUL;
            S_M0_MUL:    if (mul_rsp.done) n_state = S_M0_DEN;
            S_M0_DEN:    if (mul_rsp.done) n_state = S_M0_DIV;
            S_M0_DIV:    if (r_num[PROD_W-1] || div_rsp.done) n_state = S_OUT;
            S_OUT:       if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // unit requests
    always_comb begin
        use_mul     = 1'b0;
        use_div     = 1'b0;
        use_cor     = 1'b0;
        mul_req     = '0;
        div_req     = '0;
        cor_req     = '0;
        case (r_state)
            S_TH_MUL: begin
                use_mul = 1'b1; mul_req.a = 64'(r_flip); mul_req.b = 64'(r_b1);
            end
            S_CORDIC: begin
                use_cor = 1'b1; cor_req.z = r_z;
            end
            S_X_MUL: begin
                use_mul = 1'b1; mul_req.a = 64'(r_sig); mul_req.b = 64'(c_mag);
            end
            S_X_DIV: begin
                use_div = 1'b1;
                div_req.num = NUM_W'(r_num[55:0]);
                div_req.den = DEN_W'(s_mag);
            end
            S_Y_DIV: begin
                use_div = 1'b1;
                div_req.num = NUM_W'({r_sig, 30'd0});
                div_req.den = DEN_W'(s_mag);
            end
            S_XX_MUL: begin
                use_mul = 1'b1; mul_req.a = 64'(x_mag); mul_req.b = 64'(x_mag);
            end
            S_XY_MUL: begin
                use_mul = 1'b1; mul_req.a = 64'(x_mag); mul_req.b = 64'(y_mag);
                mul_req.neg = r_x[31] ^ r_y[31];
            end
            S_DEN1: begin
                use_mul = 1'b1; mul_req.a = 64'(r_cnt); mul_req.b = r_sum_xx;
            end
            S_DEN2: begin
                use_mul = 1'b1; mul_req.a = 64'(sx_mag); mul_req.b = 64'(sx_mag);
            end
            S_NUM1: begin
                use_mul = 1'b1; mul_req.a = 64'(r_cnt); mul_req.b = sxy_mag;
                mul_req.neg = r_sum_xy[63];
            end
            S_NUM2: begin
                use_mul = 1'b1; mul_req.a = 64'(sx_mag); mul_req.b = 64'(sy_mag);
                mul_req.neg = r_sum_x[47] ^ r_sum_y[47];
            end
            S_SLOPE_DIV: begin
                use_div = 1'b1;
                div_req.num = {r_num[DEN_W-1:0], 32'd0};
                div_req.den = r_den[DEN_W-1:0];
            end
            S_LOG_SQ: begin
                use_mul = 1'b1; mul_req.a = 64'(r_f); mul_req.b = 64'(r_f);
            end
            S_LN_HI: begin
                use_mul = 1'b1; mul_req.a = 64'(v_log[37:32]); mul_req.b = 64'(LN2_Q32);
            end
            S_LN_LO: begin
                use_mul = 1'b1; mul_req.a = 64'(v_log[31:0]); mul_req.b = 64'(LN2_Q32);
            end
            S_T1_DIV: begin
                use_div = 1'b1;
                div_req.num = NUM_W'({r_tr, 28'd0});
                div_req.den = DEN_W'(r_nl);
            end
            S_M0_MUL: begin
                use_mul = 1'b1; mul_req.a = 64'(r_slope); mul_req.b = 64'(sx_mag);
                mul_req.neg = r_sum_x[47];
            end
            S_M0_DEN: begin
                use_mul = 1'b1; mul_req.a = 64'(r_cnt); mul_req.b = 64'(one_minus);
            end
            S_M0_DIV: begin
                use_div = !r_num[PROD_W-1];
                div_req.num = r_num[NUM_W-1:0];
                div_req.den = r_den[DEN_W-1:0];
            end
            default: begin
                use_mul = 1'b0;
            end
        endcase
        mul_req.start = use_mul && !r_issued;
        div_req.start = use_div && !r_issued;
        cor_req.start = use_cor && !r_issued;
        o_in_stall    = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_tr        <= 16'd1280;
            r_b1        <= 16'd16384;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xx    <= '0;
            r_sum_xy    <= '0;
            r_cnt       <= '0;
            r_ov        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (mul_rsp.done || div_rsp.done || cor_rsp.done) begin
                r_issued <= 1'b0;
            end else if (mul_req.start || div_req.start || cor_req.start) begin
                r_issued <= 1'b1;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TR:  r_tr <= i_cfg_wdata;
                    CFG_B1:  r_b1 <= i_cfg_wdata;
                    default: r_tr <= r_tr;
                endcase
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_flip <= i_in_data.flip_angle;
                        r_sig  <= i_in_data.signal_value;
                        r_last <= i_in_data.last_point;
                        if (r_cnt >= CNT_W'(MAX_POINTS)) r_ov <= 1'b1;
                    end
                end
                S_TH_MUL: begin
                    if (mul_rsp.done) r_theta <= th_sum[32:12];
                end
                S_TH_MOD: begin
                    if (r_theta >= TWO_PI) begin
                        r_theta <= r_theta - TWO_PI;
                    end else if (r_theta > HALF_PI && r_theta < THREE_HALF_PI) begin
                        r_z     <= Z_W'(th_s - $signed({1'b0, PI_Q16}));
                        r_fsign <= 1'b1;
                    end else if (r_theta >= THREE_HALF_PI) begin
                        r_z     <= Z_W'(th_s - $signed({1'b0, TWO_PI}));
                        r_fsign <= 1'b0;
                    end else begin
                        r_z     <= Z_W'(th_s);
                        r_fsign <= 1'b0;
                    end
                end
                S_CORDIC: begin
                    if (cor_rsp.done) begin
                        r_c <= r_fsign ? -cor_rsp.c : cor_rsp.c;
                        r_s <= r_fsign ? -cor_rsp.s : cor_rsp.s;
                        if (cor_rsp.s == '0) r_ov <= 1'b1;
                    end
                end
                S_X_MUL: begin
                    if (mul_rsp.done) r_num <= mul_rsp.prod;
                end
                S_X_DIV: begin
                    if (div_rsp.done) begin
                        r_x <= (r_c[CS_W-1] ^ r_s[CS_W-1]) ? -$signed(q_clip)
                                                          : $signed(q_clip);
                        if (q_over) r_ov <= 1'b1;
                    end
                end
                S_Y_DIV: begin
                    if (div_rsp.done) begin
                        r_y <= r_s[CS_W-1] ? -$signed(q_clip) : $signed(q_clip);
                        if (q_over) r_ov <= 1'b1;
                    end
                end
                S_XX_MUL: begin
                    if (mul_rsp.done) begin
                        if (xx_sum[64]) begin
                            r_sum_xx <= '1;
                            r_ov     <= 1'b1;
                        end else begin
                            r_sum_xx <= xx_sum[63:0];
                        end
                    end
                end
                S_XY_MUL: begin
                    if (mul_rsp.done) begin
                        if (!xy_sum[65] && xy_sum[64:63] != 2'b00) begin
                            r_sum_xy <= {1'b0, {63{1'b1}}};
                            r_ov     <= 1'b1;
                        end else if (xy_sum[65] && xy_sum[64:63] != 2'b11) begin
                            r_sum_xy <= {1'b1, 63'd0};
                            r_ov     <= 1'b1;
                        end else begin
                            r_sum_xy <= xy_sum[63:0];
                        end
                        r_sum_x <= r_sum_x + 48'(r_x);
                        r_sum_y <= r_sum_y + 48'(r_y);
                        r_cnt   <= r_cnt + CNT_W'(1);
                    end
                end
                S_FIT_CHK: begin
                    if (r_cnt < CNT_W'(2)) begin
                        r_status <= FIT_FEW;
                    end else if (r_ov) begin
                        r_status <= FIT_OVERFLOW;
                    end else begin
                        r_status <= FIT_OK;
                    end
                end
                S_DEN1: if (mul_rsp.done) r_acc <= mul_rsp.prod;
                S_DEN2: if (mul_rsp.done) r_den <= r_acc - mul_rsp.prod;
                S_NUM1: if (mul_rsp.done) r_acc <= mul_rsp.prod;
                S_NUM2: if (mul_rsp.done) r_num <= r_acc - mul_rsp.prod;
                S_SLOPE_CHK: begin
                    if (r_den[PROD_W-1] || r_den == '0) begin
                        r_status <= FIT_SINGULAR;
                    end else if (r_num[PROD_W-1] || r_num == '0 || r_num >= r_den) begin
                        r_status <= FIT_SLOPE;
                    end
                end
                S_SLOPE_DIV: begin
                    if (div_rsp.done) begin
                        r_slope <= div_rsp.quo;
                        r_f     <= div_rsp.quo;
                        r_lz    <= '0;
                        if (div_rsp.quo == '0) r_status <= FIT_SLOPE;
                    end
                end
                S_NORM: begin
                    if (!r_f[31]) begin
                        r_f  <= {r_f[30:0], 1'b0};
                        r_lz <= r_lz + 5'd1;
                    end else begin
                        r_iter <= '0;
                        r_frac <= '0;
                    end
                end
                S_LOG_SQ: begin
                    if (mul_rsp.done) begin
                        r_f    <= fsq[32] ? fsq[32:1] : fsq[31:0];
                        r_frac <= {r_frac[30:0], fsq[32]};
                        r_iter <= r_iter + 5'd1;
                    end
                end
                S_LN_HI: if (mul_rsp.done) r_nl <= mul_rsp.prod[63:0];
                S_LN_LO: if (mul_rsp.done) r_nl <= r_nl + 64'(mul_rsp.prod[63:32]);
                S_T1_DIV: begin
                    if (div_rsp.done) begin
                        r_t1 <= div_rsp.quo;
                        if (div_rsp.sat) r_status <= FIT_OVERFLOW;
                    end
                end
                S_M0_MUL: if (mul_rsp.done) r_num <= sy_shift - mul_rsp.prod;
                S_M0_DEN: if (mul_rsp.done) r_den <= mul_rsp.prod;
                S_M0_DIV: begin
                    if (r_num[PROD_W-1]) begin
                        r_m0 <= '0;
                    end else if (div_rsp.done) begin
                        r_m0 <= div_rsp.quo;
                        if (div_rsp.sat) r_status <= FIT_OVERFLOW;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.fit_status <= r_status;
                        r_out.t1_time    <= (r_status != FIT_OK) ? '1 : r_t1;
                        r_out.m0_value   <= (r_status != FIT_OK) ? '1 : r_m0;
                        r_sum_x  <= '0;
                        r_sum_y  <= '0;
                        r_sum_xx <= '0;
                        r_sum_xy <= '0;
                        r_cnt    <= '0;
                        r_ov     <= 1'b0;
                    end
                end
                default: begin
                    r_ov <= r_ov;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/vfa_mul.sv =====
// Shared multiplier: 64x64 magnitude product from four 32x32 partial products.
`default_nettype none
module vfa_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vfa_pkg::t_mul_req i_req,
    output vfa_pkg::t_mul_rsp      o_rsp
);
    import vfa_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [2:0]         r_cnt;
    logic [OPD_W-1:0]   r_a;
    logic [OPD_W-1:0]   r_b;
    logic               r_neg;
    logic [63:0]        r_pp;
    logic [1:0]         r_sh;
    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_prod;
    logic [31:0]        a_h;
    logic [31:0]        b_h;
    logic [1:0]         sh_next;
    logic [PROD_W-1:0]  pp_shifted;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                a_h = r_a[31:0];  b_h = r_b[31:0];  sh_next = 2'd0;
            end
            2'd1: begin
                a_h = r_a[31:0];  b_h = r_b[63:32]; sh_next = 2'd1;
            end
            2'd2: begin
                a_h = r_a[63:32]; b_h = r_b[31:0];  sh_next = 2'd1;
            end
            default: begin
                a_h = r_a[63:32]; b_h = r_b[63:32]; sh_next = 2'd2;
            end
        endcase
    end

    always_comb begin
        case (r_sh)
            2'd0:    pp_shifted = {64'd0, r_pp};
            2'd1:    pp_shifted = {32'd0, r_pp, 32'd0};
            default: pp_shifted = {r_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_neg  <= i_req.neg;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt < 3'd4) begin
                    r_pp <= a_h * b_h;
                    r_sh <= sh_next;
                end
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                    r_acc <= r_acc + pp_shifted;
                end
                if (r_cnt == 3'd5) begin
                    r_prod <= r_neg ? (~r_acc + 1'b1) : r_acc;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = $signed(r_prod);

endmodule
`default_nettype wire

// ===== hw/rtl/vfa_div.sv =====
// Restoring divider: 32-bit saturating quotient of a wide numerator, one bit a cycle.
`default_nettype none
module vfa_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vfa_pkg::t_div_req i_req,
    output vfa_pkg::t_div_rsp      o_rsp
);
    import vfa_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic               r_sat;
    logic [4:0]         r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [31:0]        r_nlo;
    logic [QUO_W-1:0]   r_quo;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               ge;
    logic               sat_now;

    assign sat_now = (i_req.den == '0) || (i_req.num[NUM_W-1:32] >= i_req.den);
    assign trial   = {r_rem, r_nlo[31]};
    assign diff    = trial - {1'b0, r_den};
    assign ge      = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= 5'd0;
                r_den <= i_req.den;
                r_rem <= i_req.num[NUM_W-1:32];
                r_nlo <= i_req.num[31:0];
                if (sat_now) begin
                    r_sat  <= 1'b1;
                    r_quo  <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_sat  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_nlo <= {r_nlo[30:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

// ===== hw/rtl/vfa_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine in signed Q3.30.
`default_nettype none
module vfa_cordic (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vfa_pkg::t_cor_req i_req,
    output vfa_pkg::t_cor_rsp      o_rsp
);
    import vfa_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    logic                   r_busy;
    logic                   r_done;
    logic [4:0]             r_step;
    logic signed [CS_W-1:0] r_x;
    logic signed [CS_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic signed [CS_W-1:0] dx;
    logic signed [CS_W-1:0] dy;

    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 5'd0;
                r_x    <= GAIN_Q30;
                r_y    <= '0;
                r_z    <= i_req.z;
            end else if (r_busy) begin
                if (!r_z[Z_W-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_q16(r_step);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_q16(r_step);
                end
                r_step <= r_step + 5'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.c    = r_x;
    assign o_rsp.s    = r_y;

endmodule
`default_nettype wire

// ===== hw/rtl/vfa_checker.sv =====
// Port-level assertions for the VFA T1 fit top level, with its bind.
`default_nettype none
module vfa_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire vfa_pkg::t_out_item o_out_data
);
    import vfa_pkg::*;

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.fit_status == FIT_OK
            || o_out_data.fit_status == FIT_FEW
            || o_out_data.fit_status == FIT_SINGULAR
            || o_out_data.fit_status == FIT_SLOPE
            || o_out_data.fit_status == FIT_OVERFLOW))
        else $error("bad status code");

    a_error_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.fit_status != FIT_OK) |->
            (o_out_data.t1_time == 32'hFFFF_FFFF && o_out_data.m0_value == 32'hFFFF_FFFF))
        else $error("error result not saturated");

endmodule

bind variable_flip_angle_t1_fit_top vfa_checker u_vfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ===== tb/variable_flip_angle_t1_fit_top_tb.sv =====
// Testbench for the VFA T1 fit block: directed and randomized sets checked against a bit-exact fit predictor.
`timescale 1ns / 100ps
module variable_flip_angle_t1_fit_top_tb;
    import vfa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_index  cfg_index = CFG_TR;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_stall = 1'b0;
    logic        o_in_stall, o_out_valid;
    t_out_item   o_out_data;

    t_in_item  request_queue[$];
    t_out_item fit_expected[$];
    int        errors = 0;
    bit        calm = 1'b0;

    logic [15:0]    tr_reg, b1_reg;
    longint         acc_x, acc_y, acc_xy;
    longint unsigned acc_xx;
    int             acc_n;
    bit             acc_ovf;

    variable_flip_angle_t1_fit_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall), .o_out_data(o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clamp_xy(input longint v, inout bit ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483647) begin
            ovf = 1'b1;
            return -64'sd2147483647;
        end
        return v;
    endfunction

    // returns {saturated, quotient}
    function automatic logic [32:0] sat_div(input logic [127:0] nu, input logic [127:0] de);
        logic [127:0] q;
        if (de == 0) return {1'b1, 32'hFFFFFFFF};
        q = nu / de;
        if (q >= 128'h1_0000_0000) return {1'b1, 32'hFFFFFFFF};
        return {1'b0, q[31:0]};
    endfunction

    function automatic longint unsigned neg_ln_q32(input logic [31:0] e);
        int p;
        longint unsigned f, frac, v;
        p = 31;
        frac = 0;
        while (p > 0 && e[p] == 1'b0) p--;
        f = 64'(e) << (31 - p);
        for (int i = 0; i < 32; i++) begin
            f = (f * f) >> 31;
            frac = frac << 1;
            if (f >= 64'h1_0000_0000) begin
                f = f >> 1;
                frac = frac | 64'd1;
            end
        end
        v = (64'(32 - p) << 32) - frac;
        return (v >> 32) * 64'(LN2_Q32) + (((v & 64'hFFFFFFFF) * 64'(LN2_Q32)) >> 32);
    endfunction

    function automatic longint atan_tab(input int i);
        return longint'(atan_q16(5'(i)));
    endfunction

    task automatic absorb_measurement(input logic [15:0] flip, input logic [23:0] sig);
        longint unsigned theta, xx;
        longint z, c, s, cx, cy, dx, dy, x, y, p;
        bit neg;
        theta = ((64'(flip) * 64'(b1_reg) + 64'd2048) >> 12) % 64'(TWO_PI);
        z = longint'(theta);
        neg = 1'b0;
        if (theta > 64'(HALF_PI) && theta < 64'(THREE_HALF_PI)) begin
            z = z - longint'(PI_Q16);
            neg = 1'b1;
        end else if (theta >= 64'(THREE_HALF_PI)) begin
            z = z - longint'(TWO_PI);
        end
        cx = 64'sd652032874;
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx = cx - dx; cy = cy + dy; z = z - longint'(atan_tab(i));
            end else begin
                cx = cx + dx; cy = cy - dy; z = z + longint'(atan_tab(i));
            end
        end
        c = neg ? -cx : cx;
        s = neg ? -cy : cy;
        if (s == 0) begin
            acc_ovf = 1'b1;
            return;
        end
        x = clamp_xy((longint'(sig) * c) / s, acc_ovf);
        y = clamp_xy((longint'(sig) <<< 30) / s, acc_ovf);
        acc_x = acc_x + x;
        acc_y = acc_y + y;
        xx = longint'(x * x);
        if (acc_xx > 64'hFFFFFFFFFFFFFFFF - xx) begin
            acc_xx = 64'hFFFFFFFFFFFFFFFF;
            acc_ovf = 1'b1;
        end else acc_xx = acc_xx + xx;
        p = x * y;
        if (p > 0 && acc_xy > 64'sh7FFFFFFFFFFFFFFF - p) begin
            acc_xy = 64'sh7FFFFFFFFFFFFFFF;
            acc_ovf = 1'b1;
        end else if (p < 0 && acc_xy < -64'sh7FFFFFFFFFFFFFFF - 1 - p) begin
            acc_xy = -64'sh7FFFFFFFFFFFFFFF - 1;
            acc_ovf = 1'b1;
        end else acc_xy = acc_xy + p;
        acc_n++;
    endtask

    task automatic solve_fit(output t_out_item r);
        t_fit_status st;
        logic [31:0] slope, t1, m0;
        logic signed [127:0] nw, sx, sy, sxx, sxy, den, num;
        logic [32:0] d;
        bit sat;
        st = FIT_OK;
        slope = 0; t1 = 0; m0 = 0; sat = 1'b0;
        nw = acc_n; sx = acc_x; sy = acc_y; sxy = acc_xy;
        sxx = {64'd0, acc_xx};
        if (acc_n < 2) st = FIT_FEW;
        else if (acc_ovf) st = FIT_OVERFLOW;
        else begin
            den = nw * sxx - sx * sx;
            num = nw * sxy - sx * sy;
            if (den <= 0) st = FIT_SINGULAR;
            else if (num <= 0 || num >= den) st = FIT_SLOPE;
            else begin
                d = sat_div(num <<< 32, den);
                slope = d[31:0];
                if (slope == 0) st = FIT_SLOPE;
            end
        end
        if (st == FIT_OK) begin
            d = sat_div(128'(tr_reg) << 28, 128'(neg_ln_q32(slope)));
            t1 = d[31:0];
            sat = d[32];
            num = (sy <<< 32) - $signed({96'd0, slope}) * sx;
            den = nw * $signed(128'h1_0000_0000 - 128'(slope));
            if (num < 0) m0 = 0;
            else begin
                d = sat_div(num, den);
                m0 = d[31:0];
                sat = sat | d[32];
            end
            if (sat) st = FIT_OVERFLOW;
        end
        if (st != FIT_OK) begin
            t1 = 32'hFFFFFFFF;
            m0 = 32'hFFFFFFFF;
        end
        r.t1_time = t1;
        r.m0_value = m0;
        r.fit_status = st;
    endtask

    task automatic predict_request(input t_in_item it);
        t_out_item r;
        if (acc_n >= MAX_POINTS) acc_ovf = 1'b1;
        else absorb_measurement(it.flip_angle, it.signal_value);
        if (it.last_point) begin
            solve_fit(r);
            fit_expected.push_back(r);
            acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0; acc_n = 0; acc_ovf = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic     nv;
        t_in_item nd;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nv = in_valid;
            nd = in_data;
            if (in_valid && !o_in_stall) begin
                predict_request(in_data);
                void'(request_queue.pop_front());
                nv = 1'b0;
            end
            if (!nv && request_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
                nv = 1'b1;
                nd = request_queue[0];
            end
            in_valid <= nv;
            in_data <= nd;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item e;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (fit_expected.size() == 0) begin
                    $display("%0t: unexpected result actual %p", $time, o_out_data);
                    errors++;
                end else begin
                    e = fit_expected.pop_front();
                    if (o_out_data.t1_time !== e.t1_time) begin
                        $display("%0t: t1_time expected %h actual %h", $time,
                                 e.t1_time, o_out_data.t1_time);
                        errors++;
                    end
                    if (o_out_data.m0_value !== e.m0_value) begin
                        $display("%0t: m0_value expected %h actual %h", $time,
                                 e.m0_value, o_out_data.m0_value);
                        errors++;
                    end
                    if (o_out_data.fit_status !== e.fit_status) begin
                        $display("%0t: fit_status expected %0d actual %0d", $time,
                                 e.fit_status, o_out_data.fit_status);
                        errors++;
                    end
                end
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 17);
        end
    end

    task automatic push_point(input logic [15:0] f, input logic [23:0] s, input bit last);
        t_in_item it;
        it.flip_angle = f;
        it.signal_value = s;
        it.last_point = last;
        request_queue.push_back(it);
    endtask

    // one set following the spoiled gradient echo signal equation, with light noise
    task automatic push_spgr_set(input int n);
        real e1, m0, a, sg;
        int f;
        e1 = 0.5 + $urandom_range(0, 4990) / 10000.0;
        m0 = 1000.0 + $urandom_range(0, 5000000);
        for (int i = 0; i < n; i++) begin
            f = $urandom_range(500, 25000);
            a = (f / 16384.0) * (b1_reg / 16384.0);
            sg = m0 * $sin(a) * (1.0 - e1) / (1.0 - e1 * $cos(a));
            if (sg < 0.0) sg = -sg;
            sg = sg + $urandom_range(0, 6) - 3;
            if (sg < 0.0) sg = 0.0;
            if (sg > 16777215.0) sg = 16777215.0;
            push_point(16'(f), 24'($rtoi(sg)), i == n - 1);
        end
    endtask

    task automatic push_noise_set(input int n);
        for (int i = 0; i < n; i++)
            push_point(16'($urandom), 24'($urandom), i == n - 1);
    endtask

    task automatic drain;
        while (request_queue.size() > 0 || in_valid || fit_expected.size() > 0)
            @(posedge i_clk);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        if (idx == CFG_TR) tr_reg = v;
        else b1_reg = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int items);
        int sent, n, k;
        sent = 0;
        while (sent < items) begin
            k = $urandom_range(0, 99);
            if (k < 70) n = $urandom_range(2, 6);
            else if (k < 80) n = 1;
            else n = $urandom_range(7, 19);
            if (k < 85) push_spgr_set(n);
            else push_noise_set(n);
            sent += n;
        end
    endtask

    initial begin
        tr_reg = 16'd1280;
        b1_reg = 16'd16384;
        acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0; acc_n = 0; acc_ovf = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_point(16'h0000, 24'h000000, 1'b1);
        push_point(16'hFFFF, 24'hFFFFFF, 1'b0);
        push_point(16'h0000, 24'hFFFFFF, 1'b1);
        push_point(16'd8000, 24'd50000, 1'b0);
        push_point(16'd8000, 24'd50000, 1'b1);
        push_point(16'd51472, 24'd100, 1'b0);
        push_point(16'd25736, 24'hFFFFFF, 1'b1);
        for (int i = 0; i < 17; i++) push_point(16'(1000 + 900 * i), 24'd40000, i == 16);
        push_spgr_set(4);
        drain();

        random_phase(90);
        drain();
        write_reg(CFG_TR, 16'd0);
        write_reg(CFG_B1, 16'd0);
        push_spgr_set(3);
        random_phase(40);
        drain();
        write_reg(CFG_TR, 16'hFFFF);
        write_reg(CFG_B1, 16'hFFFF);
        random_phase(80);
        drain();
        write_reg(CFG_B1, 16'd15000);
        calm = 1'b1;
        random_phase(90);
        drain();
        calm = 1'b0;
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(CFG_TR, 16'($urandom));
            write_reg(CFG_B1, 16'($urandom_range(8000, 24000)));
            random_phase(80);
            drain();
        end

        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #8000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
